[sv/mset_pkg.sv]
// Package: shared types and codes for the multi-slot event timer.
`default_nettype none
package mset_pkg;

  // Number of timer slots; the four-bit slot fields cover exactly this many.
  localparam int SLOT_COUNT = 16;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_ONESHOT  = 3'd1,
    CMD_PERIODIC = 3'd2,
    CMD_CANCEL   = 3'd3,
    CMD_PAUSE    = 3'd4,
    CMD_RESUME   = 3'd5,
    CMD_RESET    = 3'd6,
    CMD_QUERY    = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_BAD_ARG  = 2'd3
  } status_e;

  localparam logic [15:0] LATE_RESET = 16'd100;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot_index;
    logic [31:0] now_ms;
    logic [30:0] delay_ms;
    logic [30:0] interval_ms;
    logic [15:0] repeat_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_slot;
    logic        fired;
    logic        missed_deadline;
    logic        slot_active;
    logic [30:0] remaining_ms;
    logic        last;
  } out_word_t;

  // One timer slot's stored fields.
  typedef struct packed {
    logic [30:0] period;
    logic [31:0] due;
    logic [15:0] reps;
  } slot_ent_t;

endpackage
`default_nettype wire

[sv/multi_slot_event_timer.sv]
// Top level: multi-slot event timer with slot table held in a synchronous memory.
//
// channel | direction | handshake               | payload
// in      | input     | in_valid_i/in_ready_o   | mset_pkg::in_word_t
// out     | output    | out_valid_o/out_ready_i | mset_pkg::out_word_t
// cfg     | input     | cfg_we_i                | late_threshold_ms (16 bits)
//
// A tick reads slot 0 in the accepting cycle, then scans one slot per cycle while
// no firing slot waits on the held word, then sends the final word in S_OUT.
// Each firing word is held one slot back so that the final one carries last.
// Single-slot commands read the slot, then modify it and write it back.
// Reset clears the marks and restores the threshold to 100; the slot memory
// is not cleared. A word waiting on out_ready_i holds the sequencer.
`default_nettype none
module multi_slot_event_timer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mset_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mset_pkg::out_word_t     out_data_o
);

  localparam int SLOT_COUNT = mset_pkg::SLOT_COUNT;
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // single slot: data arriving
  localparam logic [2:0] S_TICK = 3'd2;  // scan
  localparam logic [2:0] S_OUT  = 3'd3;  // send the tick's final word

  logic [2:0] state_q, state_d;
  logic [15:0] late_q;
  logic [SLOT_COUNT-1:0] act_q, pau_q, per_q;
  mset_pkg::in_word_t req_q;
  mset_pkg::slot_ent_t mem [SLOT_COUNT];
  mset_pkg::slot_ent_t rd_q;
  logic [IW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  mset_pkg::slot_ent_t wr_data;
  logic [CW-1:0] scan_q, scan_d;   // slot whose data is in rd_q
  logic pend_v_q, pend_v_d;
  mset_pkg::out_word_t pend_q, pend_d;
  logic out_valid_q;
  mset_pkg::out_word_t out_q;
  logic emit;
  mset_pkg::out_word_t emit_w;
  logic [IW-1:0] free_idx;
  logic free_ok;
  logic live;
  logic [IW-1:0] si;
  logic [SLOT_COUNT-1:0] act_d, pau_d, per_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Lowest inactive slot.
  always_comb begin
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        free_idx = IW'(i);
        free_ok = 1'b1;
      end
    end
  end

  assign si = req_q.slot_index[IW-1:0];
  assign live = ({28'd0, req_q.slot_index} < SLOT_COUNT) && act_q[si];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_comb begin
    logic [IW-1:0] cur;
    logic [31:0] late;
    logic [31:0] nxt;
    logic [31:0] dd;
    logic [31:0] rem;
    logic [15:0] reps;
    logic done;
    logic fire;
    logic go;
    state_d = state_q;
    scan_d = scan_q;
    pend_v_d = pend_v_q;
    pend_d = pend_q;
    act_d = act_q;
    pau_d = pau_q;
    per_d = per_q;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = rd_q;
    emit = 1'b0;
    emit_w = '0;
    cur = scan_q[IW-1:0];
    late = '0;
    nxt = '0;
    dd = '0;
    rem = '0;
    reps = '0;
    done = 1'b0;
    fire = 1'b0;
    go = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rd_en = 1'b1;
          rd_addr = (in_data_i.cmd == mset_pkg::CMD_TICK) ? '0 : in_data_i.slot_index[IW-1:0];
          scan_d = '0;
          pend_v_d = 1'b0;
          state_d = (in_data_i.cmd == mset_pkg::CMD_TICK) ? S_TICK : S_RD;
        end
      end
      S_TICK: begin
        late = req_q.now_ms - rd_q.due;
        fire = act_q[cur] && !pau_q[cur] && !late[31];
        // a firing slot may only settle once the held word can leave
        go = !fire || !pend_v_q || out_free;
        if (fire && go) begin
          if (pend_v_q) begin
            emit = 1'b1;
            emit_w = pend_q;
          end
          pend_v_d = 1'b1;
          pend_d = '0;
          pend_d.result_slot = 4'(cur);
          pend_d.fired = 1'b1;
          pend_d.missed_deadline = late > {16'd0, late_q};
          if (per_q[cur]) begin
            reps = rd_q.reps;
            if (reps != 16'd0) begin
              reps = reps - 16'd1;
              done = (reps == 16'd0);
            end
            wr_data.reps = reps;
            nxt = rd_q.due + {1'b0, rd_q.period};
            dd = req_q.now_ms - nxt;
            wr_data.due = (dd != 0 && !dd[31]) ? req_q.now_ms + {1'b0, rd_q.period} : nxt;
            if (done) act_d[cur] = 1'b0;
          end else begin
            act_d[cur] = 1'b0;
          end
          wr_en = 1'b1;
          wr_addr = cur;
        end
        if (go) begin
          if (scan_q == CW'(SLOT_COUNT - 1)) begin
            state_d = S_OUT;
          end else begin
            scan_d = scan_q + CW'(1);
            rd_en = 1'b1;
            rd_addr = IW'(scan_q + CW'(1));
          end
        end
      end
      S_OUT: begin
        // Send the held firing, or an idle word when nothing fired.
        if (out_free) begin
          emit = 1'b1;
          if (pend_v_q) emit_w = pend_q;
          emit_w.last = 1'b1;
          pend_v_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          emit = 1'b1;
          emit_w.result_slot = req_q.slot_index;
          emit_w.last = 1'b1;
          emit_w.status = mset_pkg::ST_INACTIVE;
          state_d = S_IDLE;
          unique case (mset_pkg::cmd_e'(req_q.cmd))
            mset_pkg::CMD_ONESHOT, mset_pkg::CMD_PERIODIC: begin
              emit_w.result_slot = '0;
              if (req_q.cmd == mset_pkg::CMD_PERIODIC && req_q.interval_ms == '0) begin
                emit_w.status = mset_pkg::ST_BAD_ARG;
              end else if (!free_ok) begin
                emit_w.status = mset_pkg::ST_NO_SLOT;
              end else begin
                emit_w.status = mset_pkg::ST_OK;
                emit_w.result_slot = 4'(free_idx);
                act_d[free_idx] = 1'b1;
                pau_d[free_idx] = 1'b0;
                wr_en = 1'b1;
                wr_addr = free_idx;
                if (req_q.cmd == mset_pkg::CMD_ONESHOT) begin
                  per_d[free_idx] = 1'b0;
                  wr_data.period = '0;
                  wr_data.reps = 16'd1;
                  wr_data.due = req_q.now_ms + {1'b0, req_q.delay_ms};
                end else begin
                  per_d[free_idx] = 1'b1;
                  wr_data.period = req_q.interval_ms;
                  wr_data.reps = req_q.repeat_count;
                  wr_data.due = req_q.now_ms + {1'b0, (req_q.delay_ms != '0) ?
                                req_q.delay_ms : req_q.interval_ms};
                end
              end
            end
            mset_pkg::CMD_CANCEL: begin
              if (live) begin
                emit_w.status = mset_pkg::ST_OK;
                act_d[si] = 1'b0;
                pau_d[si] = 1'b0;
              end
            end
            mset_pkg::CMD_PAUSE: begin
              if (live) begin
                emit_w.status = mset_pkg::ST_OK;
                pau_d[si] = 1'b1;
              end
            end
            mset_pkg::CMD_RESUME: begin
              if (live && pau_q[si]) begin
                emit_w.status = mset_pkg::ST_OK;
                pau_d[si] = 1'b0;
                wr_en = 1'b1;
                wr_addr = si;
                wr_data.due = req_q.now_ms + {1'b0, rd_q.period};
              end
            end
            mset_pkg::CMD_RESET: begin
              if (req_q.interval_ms == '0) begin
                emit_w.status = mset_pkg::ST_BAD_ARG;
              end else if (live && per_q[si]) begin
                emit_w.status = mset_pkg::ST_OK;
                wr_en = 1'b1;
                wr_addr = si;
                wr_data.period = req_q.interval_ms;
                wr_data.due = req_q.now_ms + {1'b0, req_q.interval_ms};
              end
            end
            mset_pkg::CMD_QUERY: begin
              if (live) begin
                emit_w.status = mset_pkg::ST_OK;
                emit_w.slot_active = 1'b1;
                rem = rd_q.due - req_q.now_ms;
                emit_w.remaining_ms = rem[31] ? '0 : rem[30:0];
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      late_q <= mset_pkg::LATE_RESET;
      act_q <= '0;
      pau_q <= '0;
      per_q <= '0;
      scan_q <= '0;
      pend_v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q <= scan_d;
      pend_v_q <= pend_v_d;
      act_q <= act_d;
      pau_q <= pau_d;
      per_q <= per_d;
      if (cfg_we_i) late_q <= cfg_data_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) req_q <= in_data_i;
    if (emit) out_q <= emit_w;
    pend_q <= pend_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  ap_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !emit || out_ready_i || !out_valid_q)
    else $error("result overwritten while held");
  ap_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("held result changed");
  ap_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> in_ready_o)
    else $error("idle sequencer refuses input");
  ap_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q < CW'(SLOT_COUNT))
    else $error("scan index beyond table");

endmodule
`default_nettype wire

[tb/sv/tb_multi_slot_event_timer.sv]
// Testbench for the multi-slot event timer: random and directed commands, predicted results.
`default_nettype none
module tb_multi_slot_event_timer;

  localparam int NSLOT = mset_pkg::SLOT_COUNT;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  mset_pkg::in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  mset_pkg::out_word_t out_data_o;

  multi_slot_event_timer i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o,
    .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predicted timer table.
  logic [15:0] late_lim;
  logic        t_act [NSLOT];
  logic        t_pau [NSLOT];
  logic        t_per [NSLOT];
  logic [30:0] t_ival [NSLOT];
  logic [31:0] t_due [NSLOT];
  logic [15:0] t_reps [NSLOT];

  mset_pkg::in_word_t  pending_words[$];
  mset_pkg::out_word_t awaited_words[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle = 26;
  int        recv_idle = 68;
  logic      hold_send = 1'b0;

  function automatic void queue_result(input mset_pkg::out_word_t r);
    awaited_words = {awaited_words, r};
  endfunction

  function automatic void queue_cmd(input mset_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic mset_pkg::out_word_t mk(logic [1:0] st, logic [3:0] sl);
    mset_pkg::out_word_t w;
    w = '0;
    w.status = st;
    w.result_slot = sl;
    w.last = 1'b1;
    return w;
  endfunction

  task automatic predict_timer(input mset_pkg::in_word_t w);
    mset_pkg::out_word_t r;
    logic [31:0] late, nxt, d;
    int n, s;
    logic live;
    n = 0;
    s = -1;
    live = t_act[w.slot_index];
    case (mset_pkg::cmd_e'(w.cmd))
      mset_pkg::CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (t_act[i] && !t_pau[i]) begin
            late = w.now_ms - t_due[i];
            if (!late[31]) begin
              r = '0;
              r.result_slot = i[3:0];
              r.fired = 1'b1;
              r.missed_deadline = late > {16'd0, late_lim};
              if (t_per[i]) begin
                if (t_reps[i] == 16'd1) t_act[i] = 1'b0;
                else begin
                  if (t_reps[i] != 0) t_reps[i]--;
                  nxt = t_due[i] + {1'b0, t_ival[i]};
                  d = w.now_ms - nxt;
                  t_due[i] = (d != 0 && !d[31]) ? w.now_ms + {1'b0, t_ival[i]} : nxt;
                end
              end else t_act[i] = 1'b0;
              queue_result(r);
              n++;
            end
          end
        end
        if (n == 0) queue_result(mk(mset_pkg::ST_OK, 4'd0));
        else awaited_words[$].last = 1'b1;
      end
      mset_pkg::CMD_ONESHOT, mset_pkg::CMD_PERIODIC: begin
        if (w.cmd == mset_pkg::CMD_PERIODIC && w.interval_ms == 0) begin
          queue_result(mk(mset_pkg::ST_BAD_ARG, 4'd0));
        end else begin
          for (int i = NSLOT - 1; i >= 0; i--) if (!t_act[i]) s = i;
          if (s < 0) queue_result(mk(mset_pkg::ST_NO_SLOT, 4'd0));
          else begin
            t_act[s] = 1'b1;
            t_pau[s] = 1'b0;
            if (w.cmd == mset_pkg::CMD_ONESHOT) begin
              t_per[s] = 1'b0; t_ival[s] = '0; t_reps[s] = 16'd1;
              t_due[s] = w.now_ms + {1'b0, w.delay_ms};
            end else begin
              t_per[s] = 1'b1; t_ival[s] = w.interval_ms; t_reps[s] = w.repeat_count;
              t_due[s] = w.now_ms + {1'b0, (w.delay_ms != 0) ? w.delay_ms : w.interval_ms};
            end
            queue_result(mk(mset_pkg::ST_OK, s[3:0]));
          end
        end
      end
      mset_pkg::CMD_CANCEL: begin
        if (live) begin t_act[w.slot_index] = 1'b0; t_pau[w.slot_index] = 1'b0; end
        queue_result(mk(live ? mset_pkg::ST_OK : mset_pkg::ST_INACTIVE, w.slot_index));
      end
      mset_pkg::CMD_PAUSE: begin
        if (live) t_pau[w.slot_index] = 1'b1;
        queue_result(mk(live ? mset_pkg::ST_OK : mset_pkg::ST_INACTIVE, w.slot_index));
      end
      mset_pkg::CMD_RESUME: begin
        live = live && t_pau[w.slot_index];
        if (live) begin
          t_pau[w.slot_index] = 1'b0;
          t_due[w.slot_index] = w.now_ms + {1'b0, t_ival[w.slot_index]};
        end
        queue_result(mk(live ? mset_pkg::ST_OK : mset_pkg::ST_INACTIVE, w.slot_index));
      end
      mset_pkg::CMD_RESET: begin
        if (w.interval_ms == 0) queue_result(mk(mset_pkg::ST_BAD_ARG, w.slot_index));
        else begin
          live = live && t_per[w.slot_index];
          if (live) begin
            t_ival[w.slot_index] = w.interval_ms;
            t_due[w.slot_index] = w.now_ms + {1'b0, w.interval_ms};
          end
          queue_result(mk(live ? mset_pkg::ST_OK : mset_pkg::ST_INACTIVE, w.slot_index));
        end
      end
      default: begin
        r = mk(live ? mset_pkg::ST_OK : mset_pkg::ST_INACTIVE, w.slot_index);
        if (live) begin
          d = t_due[w.slot_index] - w.now_ms;
          r.slot_active = 1'b1;
          r.remaining_ms = (d == 0 || d[31]) ? 31'd0 : d[30:0];
        end
        queue_result(r);
      end
    endcase
  endtask

  // Driver: present pending words, advance on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_timer(in_data_i);
        void'(pending_words.pop_front());
      end
      // hold a word that is still waiting
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && !hold_send
            && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_words[0];
        end else in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        if (out_data_o !== awaited_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", awaited_words[0], out_data_o);
        end
        void'(awaited_words.pop_front());
      end
    end
  end

  initial begin
    if (1) begin
      wait (cycles >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic mset_pkg::in_word_t rand_word(logic [31:0] now);
    mset_pkg::in_word_t w;
    int k;
    w.cmd = 3'($urandom_range(7));
    k = int'($urandom_range(9));
    if (k < 3) w.cmd = mset_pkg::CMD_TICK;
    else if (k < 5) w.cmd = ($urandom_range(1) != 0) ? mset_pkg::CMD_ONESHOT
                                                      : mset_pkg::CMD_PERIODIC;
    w.slot_index = 4'($urandom_range(15));
    w.now_ms = now;
    w.delay_ms = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(300));
    w.interval_ms = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(200));
    w.repeat_count = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
    return w;
  endfunction

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || awaited_words.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    late_lim = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] now;
    mset_pkg::in_word_t w;
    late_lim = mset_pkg::LATE_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      t_act[i] = 0; t_pau[i] = 0; t_per[i] = 0;
      t_ival[i] = 0; t_due[i] = 0; t_reps[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: errors on empty table, create extremes, fill, fire.
    now = 32'hFFFF_FF00;
    w = '0; w.now_ms = now;
    w.cmd = mset_pkg::CMD_QUERY; w.slot_index = 4'd15; queue_cmd(w);
    w.cmd = mset_pkg::CMD_CANCEL; queue_cmd(w);
    w.cmd = mset_pkg::CMD_PAUSE; queue_cmd(w);
    w.cmd = mset_pkg::CMD_RESUME; queue_cmd(w);
    w.cmd = mset_pkg::CMD_RESET; queue_cmd(w);
    w.interval_ms = 31'h7FFF_FFFF; queue_cmd(w);
    w.cmd = mset_pkg::CMD_PERIODIC; w.interval_ms = 0; queue_cmd(w);
    w.cmd = mset_pkg::CMD_TICK; queue_cmd(w);
    for (int i = 0; i < 17; i++) begin
      w.cmd = (i % 2) ? mset_pkg::CMD_ONESHOT : mset_pkg::CMD_PERIODIC;
      w.delay_ms = (i == 3) ? 31'h7FFF_FFFF : 31'(i * 10);
      w.interval_ms = (i == 4) ? 31'h7FFF_FFFF : 31'd50;
      w.repeat_count = (i == 2) ? 16'hFFFF : 16'(i % 3);
      queue_cmd(w);
    end
    w.cmd = mset_pkg::CMD_PAUSE; w.slot_index = 4'd0; queue_cmd(w);
    w.cmd = mset_pkg::CMD_QUERY; w.slot_index = 4'd5; queue_cmd(w);
    w.cmd = mset_pkg::CMD_TICK; w.now_ms = now + 32'd500; queue_cmd(w);
    w.cmd = mset_pkg::CMD_RESUME; w.slot_index = 4'd0; queue_cmd(w);
    w.cmd = mset_pkg::CMD_RESET; w.interval_ms = 31'd7; queue_cmd(w);
    w.cmd = mset_pkg::CMD_TICK; w.now_ms = now + 32'd520; queue_cmd(w);
    now = now + 32'd600;
    // Random phases with differing threshold and idling.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: write_limit(16'd0);
        1: begin write_limit(16'hFFFF); send_idle = 68; recv_idle = 26; end
        2: begin write_limit(16'd20); send_idle = 0; recv_idle = 0; end
        default: write_limit(16'd100);
      endcase
      for (int i = 0; i < 57; i++) begin
        now = now + (($urandom_range(15) == 0) ? $urandom : $urandom_range(60));
        queue_cmd(rand_word(now));
      end
      if (ph == 1) begin
        while (pending_words.size() > 30) @(posedge clk_i);
        hold_send = 1'b1;
        while (awaited_words.size() != 0 || in_valid_i) @(posedge clk_i);
        hold_send = 1'b0;
      end
    end
    wait_idle();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
